>>> rtl/core/mlsc_pkg.sv
// ============================================================================
// mlsc_pkg
// shared types, constants and helpers of the perceptron classifier
// ============================================================================
`default_nettype none

package mlsc_pkg;

    // input item kinds, carried on s_axis_tuser
    typedef enum logic
    {
        OP_FEATURE = 1'b0,
        OP_TABLE   = 1'b1
    } op_t;

    // kinds of queue entries handed from front to back
    typedef enum logic
    {
        KIND_SAMPLE = 1'b0,
        KIND_TABLE  = 1'b1
    } entry_kind_t;

    // configuration register indexes
    localparam logic [1:0] REG_HIDDEN0 = 2'd0;
    localparam logic [1:0] REG_HIDDEN1 = 2'd1;
    localparam logic [1:0] REG_OUTPUT  = 2'd2;
    localparam logic [1:0] REG_BATCH   = 2'd3;

    localparam int FEATURES_DEFAULT = 7;
    localparam int SUM_W            = 19;
    localparam int PROD_W           = 17;
    localparam int QUEUE_DEPTH      = 4;
    localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed
    {
        entry_kind_t              kind;
        logic signed [SUM_W-1:0]  sum_a;
        logic signed [SUM_W-1:0]  sum_b;
        logic                     last;
        logic [7:0]               tbl_index;
        logic [7:0]               tbl_value;
    } queue_entry_t;

    // signed byte k of a packed coefficient word
    function automatic logic signed [7:0] coeff_byte(input logic [63:0] w,
                                                     input logic [2:0]  k);
        coeff_byte = $signed(w[{k, 3'b000} +: 8]);
    endfunction

    // bias * 255 as (b << 8) - b
    function automatic logic signed [SUM_W-1:0] scale255(input logic signed [7:0] b);
        logic signed [SUM_W-1:0] x;
        x = {{(SUM_W-8){b[7]}}, b};
        scale255 = (x <<< 8) - x;
    endfunction

    // floor(sum / 32) + 128, clamped to 0..255
    function automatic logic [7:0] act_index(input logic signed [SUM_W-1:0] s);
        logic signed [SUM_W-5:0] q;
        q = $signed({s[SUM_W-1], s[SUM_W-1:5]}) + $signed((SUM_W-4)'(128));
        if (q < $signed((SUM_W-4)'(0)))
        begin
            act_index = 8'd0;
        end
        else if (q > $signed((SUM_W-4)'(255)))
        begin
            act_index = 8'd255;
        end
        else
        begin
            act_index = q[7:0];
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/mlsc_front.sv
// ============================================================================
// mlsc_front
// accepts words, accumulates both hidden neurons, queues samples and table writes
// ============================================================================
`default_nettype none

module mlsc_front #(
    parameter int FEATURES_PER_SAMPLE = mlsc_pkg::FEATURES_DEFAULT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output      logic                   in_ready,
    input  wire mlsc_pkg::op_t          in_op,
    input  wire logic [7:0]             feature,
    input  wire logic [7:0]             table_index,
    input  wire logic [7:0]             table_value,
    input  wire logic [63:0]            hidden0_coeffs,
    input  wire logic [63:0]            hidden1_coeffs,
    input  wire logic [15:0]            samples_per_batch,
    input  wire logic                   q_full,
    output      logic                   q_push,
    output      mlsc_pkg::queue_entry_t q_entry
);
    import mlsc_pkg::*;

    localparam logic [2:0] LAST_POS = 3'(FEATURES_PER_SAMPLE - 1);

    logic signed [SUM_W-1:0]  sum_a_reg, sum_a_next;
    logic signed [SUM_W-1:0]  sum_b_reg, sum_b_next;
    logic [2:0]               pos_reg, pos_next;
    logic [15:0]              count_reg, count_next;
    logic                     accept, take_feature, pos_last, batch_last;
    logic [2:0]               w_sel;
    logic signed [7:0]        w_a, w_b;
    logic signed [PROD_W-1:0] prod_a, prod_b;
    logic signed [SUM_W-1:0]  base_a, base_b;

    assign in_ready     = !q_full;
    assign accept       = in_valid && in_ready;
    assign take_feature = accept && (in_op == OP_FEATURE);

    assign w_sel  = pos_reg + 3'd1;
    assign w_a    = coeff_byte(hidden0_coeffs, w_sel);
    assign w_b    = coeff_byte(hidden1_coeffs, w_sel);
    assign prod_a = $signed({1'b0, feature}) * w_a;
    assign prod_b = $signed({1'b0, feature}) * w_b;

    // a new sample starts from bias * 255
    assign base_a = (pos_reg == 3'd0) ? scale255(coeff_byte(hidden0_coeffs, 3'd0)) : sum_a_reg;
    assign base_b = (pos_reg == 3'd0) ? scale255(coeff_byte(hidden1_coeffs, 3'd0)) : sum_b_reg;

    assign sum_a_next = base_a + {{(SUM_W-PROD_W){prod_a[PROD_W-1]}}, prod_a};
    assign sum_b_next = base_b + {{(SUM_W-PROD_W){prod_b[PROD_W-1]}}, prod_b};

    assign pos_last   = (pos_reg >= LAST_POS);
    assign pos_next   = pos_last ? 3'd0 : pos_reg + 3'd1;
    assign batch_last = (count_reg == samples_per_batch - 16'd1);
    assign count_next = batch_last ? 16'd0 : count_reg + 16'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_a_reg <= '0;
            sum_b_reg <= '0;
            pos_reg   <= '0;
            count_reg <= '0;
        end
        else if (take_feature)
        begin
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            pos_reg   <= pos_next;
            if (pos_last)
            begin
                count_reg <= count_next;
            end
        end
    end

    // table writes travel through the queue to keep order with samples
    assign q_push = accept && ((in_op == OP_TABLE) || pos_last);

    always_comb
    begin
        q_entry.kind      = (in_op == OP_TABLE) ? KIND_TABLE : KIND_SAMPLE;
        q_entry.sum_a     = sum_a_next;
        q_entry.sum_b     = sum_b_next;
        q_entry.last      = batch_last;
        q_entry.tbl_index = table_index;
        q_entry.tbl_value = table_value;
    end

`ifndef SYNTH
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= LAST_POS)
        else $error("feature position beyond sample length");
`endif

endmodule

`default_nettype wire

>>> rtl/core/mlsc_queue.sv
// ============================================================================
// mlsc_queue
// short first-in first-out queue between front and back
// ============================================================================
`default_nettype none

module mlsc_queue (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   push,
    input  wire mlsc_pkg::queue_entry_t push_entry,
    input  wire logic                   pop,
    output      mlsc_pkg::queue_entry_t head,
    output      logic                   full,
    output      logic                   empty
);
    import mlsc_pkg::*;

    queue_entry_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

>>> rtl/core/mlsc_back.sv
// ============================================================================
// mlsc_back
// activation table, output neuron and result register
// ============================================================================
`default_nettype none

module mlsc_back (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   q_empty,
    input  wire mlsc_pkg::queue_entry_t q_head,
    output      logic                   q_pop,
    input  wire logic [23:0]            output_coeffs,
    output      logic                   out_valid,
    input  wire logic                   out_ready,
    output      logic                   decision,
    output      logic                   batch_end
);
    import mlsc_pkg::*;

    logic [7:0]               act_mem [256];
    logic [255:0]             tbl_valid_reg;
    logic                     adv, is_table;
    logic [7:0]               idx_a, idx_b;

    // stage 1: table read
    logic                     b1_valid_reg, b1_last_reg;
    logic [7:0]               rd_a_reg, rd_b_reg;
    logic                     ok_a_reg, ok_b_reg;
    logic [7:0]               act_a, act_b;

    // stage 2: products
    logic                     b2_valid_reg, b2_last_reg;
    logic signed [PROD_W-1:0] p_a_reg, p_b_reg;
    logic signed [SUM_W-1:0]  acc;

    // result register
    logic                     out_valid_reg, decision_reg, batch_end_reg;

    assign adv      = !out_valid_reg || out_ready;
    assign q_pop    = adv && !q_empty;
    assign is_table = (q_head.kind == KIND_TABLE);
    assign idx_a    = act_index(q_head.sum_a);
    assign idx_b    = act_index(q_head.sum_b);

    always_ff @(posedge clk)
    begin
        if (q_pop && is_table)
        begin
            act_mem[q_head.tbl_index] <= q_head.tbl_value;
        end
        if (q_pop)
        begin
            rd_a_reg <= act_mem[idx_a];
            rd_b_reg <= act_mem[idx_b];
        end
    end

    // never-written entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tbl_valid_reg <= '0;
        end
        else if (q_pop && is_table)
        begin
            tbl_valid_reg[q_head.tbl_index] <= 1'b1;
        end
    end

    assign act_a = ok_a_reg ? rd_a_reg : 8'd0;
    assign act_b = ok_b_reg ? rd_b_reg : 8'd0;

    assign acc = scale255(coeff_byte({40'd0, output_coeffs}, 3'd0))
               + {{(SUM_W-PROD_W){p_a_reg[PROD_W-1]}}, p_a_reg}
               + {{(SUM_W-PROD_W){p_b_reg[PROD_W-1]}}, p_b_reg};

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ok_a_reg      <= tbl_valid_reg[idx_a];
            ok_b_reg      <= tbl_valid_reg[idx_b];
            b1_last_reg   <= q_head.last;
            p_a_reg       <= $signed({1'b0, act_a}) * coeff_byte({40'd0, output_coeffs}, 3'd1);
            p_b_reg       <= $signed({1'b0, act_b}) * coeff_byte({40'd0, output_coeffs}, 3'd2);
            b2_last_reg   <= b1_last_reg;
            decision_reg  <= !acc[SUM_W-1] && (acc != '0);
            batch_end_reg <= b2_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg  <= 1'b0;
            b2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            b1_valid_reg  <= q_pop && !is_table;
            b2_valid_reg  <= b1_valid_reg;
            out_valid_reg <= b2_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign decision  = decision_reg;
    assign batch_end = batch_end_reg;

endmodule

`default_nettype wire

>>> rtl/core/mlp_lut_sigmoid_classifier.sv
// path: a sample's last feature enters the queue, then passes the table read, product and result registers
// throughput: one word per cycle in while the queue is not full; the front does both multiply-accumulates per word
// one result per sample; the back pipeline retires one queue entry per cycle while the output is not stalled
// reset: config registers return to reset values, accumulators and counters clear
// reset: activation table reads as zero through per-entry valid bits, no clearing pass
// ============================================================================
// mlp_lut_sigmoid_classifier
// two-neuron quantized perceptron with a loadable activation table
// ============================================================================
`default_nettype none

module mlp_lut_sigmoid_classifier #(
    parameter int FEATURES_PER_SAMPLE = mlsc_pkg::FEATURES_DEFAULT
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // input words
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // feature[7:0], table_index[15:8], table_value[23:16]
    input  wire logic        s_axis_tuser,   // op[0]

    // result words
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output      logic [7:0]  m_axis_tdata,   // decision[0], zeros[7:1]
    output      logic        m_axis_tlast,   // batch_end

    // configuration writes
    input  wire logic        cfg_valid,
    output      logic        cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    import mlsc_pkg::*;

    // configuration registers
    logic [63:0]  hidden0_reg;
    logic [63:0]  hidden1_reg;
    logic [23:0]  output_reg;
    logic [15:0]  batch_reg;

    // front to queue, queue to back
    logic         q_push, q_pop, q_full, q_empty;
    queue_entry_t q_entry, q_head;
    logic         decision;

    // config writes are always taken
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hidden0_reg <= '0;
            hidden1_reg <= '0;
            output_reg  <= '0;
            batch_reg   <= 16'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_HIDDEN0: hidden0_reg <= cfg_data;
                REG_HIDDEN1: hidden1_reg <= cfg_data;
                REG_OUTPUT:  output_reg  <= cfg_data[23:0];
                REG_BATCH:   batch_reg   <= cfg_data[15:0];
                default:     ;
            endcase
        end
    end

    // front: accumulates features, forwards finished samples and table writes
    mlsc_front #(
        .FEATURES_PER_SAMPLE (FEATURES_PER_SAMPLE)
    ) u_front (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (s_axis_tvalid),
        .in_ready          (s_axis_tready),
        .in_op             (op_t'(s_axis_tuser)),
        .feature           (s_axis_tdata[7:0]),
        .table_index       (s_axis_tdata[15:8]),
        .table_value       (s_axis_tdata[23:16]),
        .hidden0_coeffs    (hidden0_reg),
        .hidden1_coeffs    (hidden1_reg),
        .samples_per_batch (batch_reg),
        .q_full            (q_full),
        .q_push            (q_push),
        .q_entry           (q_entry)
    );

    // queue lets the front keep taking words while the output stalls
    mlsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .pop        (q_pop),
        .head       (q_head),
        .full       (q_full),
        .empty      (q_empty)
    );

    // back: table lookup, output neuron, result register
    mlsc_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .output_coeffs (output_reg),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .decision      (decision),
        .batch_end     (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, decision};

endmodule

`default_nettype wire

>>> dv/tb_mlp_lut_sigmoid_classifier.sv
`timescale 1ns / 100ps
// ============================================================================
// tb_mlp_lut_sigmoid_classifier
// self-checking bench for the two-neuron lut classifier: feature and table
// words go in with random gaps, an in-bench model predicts every decision and
// batch marker, and each result word is compared in order with its prediction
// ============================================================================

module tb_mlp_lut_sigmoid_classifier;
    import mlsc_pkg::*;

    localparam int FEATURES      = FEATURES_DEFAULT;
    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 4;
    // margin for the back end after the last predicted result
    localparam int SETTLE_CYCLES = 8;
    // long receiver hold-off that backs the block up into its input
    localparam int HOLD_CYCLES   = 300;
    // cycles with no word moving on any channel before the run is declared hung
    localparam int IDLE_LIMIT    = 2000;
    localparam int MAX_REPORTS   = 10;

    // coefficient flavors used to steer the hidden sums
    typedef enum int
    {
        STYLE_RANDOM = 0,
        STYLE_MAX    = 1,
        STYLE_MIN    = 2,
        STYLE_SMALL  = 3
    } coeff_style_t;

    // one predicted result word
    typedef struct packed
    {
        logic decision;
        logic batch_end;
    } verdict_t;

    // ------------------------------------------------------------------------
    // scoreboard: mirrors registers, accumulators, counter and table, and
    // keeps the predicted verdicts in arrival order
    // ------------------------------------------------------------------------
    class verdict_scoreboard;
        logic [63:0] hidden0_w;
        logic [63:0] hidden1_w;
        logic [23:0] output_w;
        logic [15:0] batch_len;
        int          acc_a;
        int          acc_b;
        int          slot;
        logic [15:0] sample_idx;
        logic [7:0]  act_lut [0:255];
        verdict_t    pending_q [$];
        int unsigned errors;
        int unsigned words_noted;
        int unsigned table_loads;
        int unsigned verdicts_checked;
        int unsigned batch_ends;

        function new();
            int i;
            hidden0_w        = '0;
            hidden1_w        = '0;
            output_w         = '0;
            batch_len        = 16'd1;
            acc_a            = 0;
            acc_b            = 0;
            slot             = 0;
            sample_idx       = '0;
            errors           = 0;
            words_noted      = 0;
            table_loads      = 0;
            verdicts_checked = 0;
            batch_ends       = 0;
            for (i = 0; i < 256; i++)
            begin
                act_lut[i] = 8'd0;
            end
        endfunction

        // signed byte k of a packed coefficient word
        function int coeff(logic [63:0] w, int k);
            logic signed [7:0] b;
            b = w[8*k +: 8];
            return int'(b);
        endfunction

        // floor(sum / 32) + 128 clamped to the table range
        function int lut_slot(int sum);
            int q;
            q = (sum >>> 5) + 128;
            if (q < 0)
            begin
                q = 0;
            end
            else if (q > 255)
            begin
                q = 255;
            end
            return q;
        endfunction

        function void write_reg(logic [1:0] idx, logic [63:0] data);
            case (idx)
                REG_HIDDEN0: hidden0_w = data;
                REG_HIDDEN1: hidden1_w = data;
                REG_OUTPUT:  output_w  = data[23:0];
                REG_BATCH:   batch_len = data[15:0];
                default:     ;
            endcase
        endfunction

        // one accepted input word
        function void note_word(op_t op, logic [23:0] data);
            int       feat;
            int       sum_a;
            int       sum_b;
            int       out_acc;
            logic     last;
            verdict_t v;
            words_noted++;
            if (op == OP_TABLE)
            begin
                act_lut[data[15:8]] = data[23:16];
                table_loads++;
                return;
            end
            feat = data[7:0];
            if (slot == 0)
            begin
                sum_a = coeff(hidden0_w, 0) * 255;
                sum_b = coeff(hidden1_w, 0) * 255;
            end
            else
            begin
                sum_a = acc_a;
                sum_b = acc_b;
            end
            sum_a += feat * coeff(hidden0_w, slot + 1);
            sum_b += feat * coeff(hidden1_w, slot + 1);
            acc_a = sum_a;
            acc_b = sum_b;
            if (slot < FEATURES - 1)
            begin
                slot++;
                return;
            end
            slot    = 0;
            out_acc = coeff({40'd0, output_w}, 0) * 255
                    + int'(act_lut[lut_slot(sum_a)]) * coeff({40'd0, output_w}, 1)
                    + int'(act_lut[lut_slot(sum_b)]) * coeff({40'd0, output_w}, 2);
            last       = (sample_idx == batch_len - 16'd1);
            sample_idx = last ? 16'd0 : sample_idx + 16'd1;
            v.decision  = (out_acc > 0);
            v.batch_end = last;
            pending_q.push_back(v);
        endfunction

        // one accepted result word against the oldest prediction
        function void check_word(logic decision, logic batch_end);
            verdict_t want;
            verdicts_checked++;
            if (batch_end)
            begin
                batch_ends++;
            end
            if (pending_q.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("%0t: result word with nothing pending: decision %0b batch_end %0b",
                             $time, decision, batch_end);
                end
                return;
            end
            want = pending_q.pop_front();
            if (want.decision !== decision || want.batch_end !== batch_end)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                begin
                    $display("%0t: result %0d: decision exp %0b got %0b, batch_end exp %0b got %0b",
                             $time, verdicts_checked, want.decision, decision,
                             want.batch_end, batch_end);
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n;

    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;    // feature[7:0], table_index[15:8], table_value[23:16]
    logic        s_axis_tuser;    // op[0]

    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;    // decision[0], zeros[7:1]
    logic        m_axis_tlast;    // batch_end

    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    verdict_scoreboard sb;

    // per-phase idling bounds, read by the sender tasks and the result sink
    int unsigned send_max_gap = 0;
    int unsigned recv_max_gap = 0;
    // raised by the stimulus, taken and cleared by the result sink
    bit          hold_pending = 1'b0;

    mlp_lut_sigmoid_classifier #(
        .FEATURES_PER_SAMPLE(FEATURES)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 12 ns clock, first rising edge at 6 ns
    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // driver tasks: inputs move on the falling edge, handshakes are sampled
    // on the rising edge
    // ------------------------------------------------------------------------

    // offer one word after gap idle cycles and hold it until accepted;
    // with no gap valid simply stays high into the next word
    task automatic send_word(input op_t op, input logic [23:0] data, input int unsigned gap);
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_word(op, data);
    endtask

    // feature word, table fields filled with noise
    task automatic send_feature(input logic [7:0] f);
        logic [23:0] data;
        data       = 24'($urandom);
        data[7:0]  = f;
        send_word(OP_FEATURE, data, $urandom_range(send_max_gap, 0));
    endtask

    // table load word, feature field filled with noise
    task automatic send_table(input logic [7:0] idx, input logic [7:0] val);
        logic [23:0] data;
        data        = 24'($urandom);
        data[15:8]  = idx;
        data[23:16] = val;
        send_word(OP_TABLE, data, $urandom_range(send_max_gap, 0));
    endtask

    // mostly features with the extremes weighted up, one in ten a table load
    task automatic send_random_word();
        logic [7:0] f;
        if ($urandom_range(9, 0) == 0)
        begin
            send_table(8'($urandom), 8'($urandom));
        end
        else
        begin
            case ($urandom_range(7, 0))
                0:       f = 8'h00;
                1:       f = 8'hFF;
                default: f = 8'($urandom);
            endcase
            send_feature(f);
        end
    endtask

    task automatic run_samples(input int n);
        int i;
        int k;
        for (i = 0; i < n; i++)
        begin
            for (k = 0; k < FEATURES; k++)
            begin
                send_feature(8'($urandom));
            end
        end
    endtask

    // drop valid, wait for every predicted word, then let words that make
    // no result (table loads, partial samples) drain out of the pipeline
    task automatic settle_block();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [1:0] idx, input logic [63:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] pick_coeffs(input coeff_style_t style);
        logic [63:0] w;
        int          k;
        w = '0;
        case (style)
            STYLE_RANDOM: w = {$urandom, $urandom};
            STYLE_MAX:    w = 64'h7F7F_7F7F_7F7F_7F7F;
            STYLE_MIN:    w = 64'h8080_8080_8080_8080;
            default:
            begin
                // small weights from -4 to +4; the sums can still reach the clamped ends of the table range
                for (k = 0; k < 8; k++)
                begin
                    w[8*k +: 8] = 8'($urandom_range(8, 0) - 4);
                end
            end
        endcase
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // result sink: random back-pressure, one long hold-off on request
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned gap;
        m_axis_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (hold_pending)
            begin
                gap          = HOLD_CYCLES;
                hold_pending = 1'b0;
            end
            else
            begin
                gap = $urandom_range(recv_max_gap, 0);
            end
            if (gap > 0)
            begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            sb.check_word(m_axis_tdata[0], m_axis_tlast);
        end
    end

    // ------------------------------------------------------------------------
    // watchdog: any word moving on any channel restarts the count
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int unsigned idle;
        idle = 0;
        while (idle < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (cfg_valid && cfg_ready))
            begin
                idle = 0;
            end
            else
            begin
                idle++;
            end
        end
        $display("no word moved for %0d cycles", IDLE_LIMIT);
        $display("tb_mlp_lut_sigmoid_classifier: errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int           phase;
        int           n;
        int           i;
        logic [63:0]  wo;
        logic [15:0]  bsz;
        coeff_style_t style;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        sb            = new();

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // ---------------- directed part ----------------
        send_max_gap = 0;
        recv_max_gap = 19;
        // neuron 0 all +127, neuron 1 all -128: sums hit both clamp ends
        write_cfg(REG_HIDDEN0, 64'h7F7F_7F7F_7F7F_7F7F);
        write_cfg(REG_HIDDEN1, 64'h8080_8080_8080_8080);
        // output bias +1, act0 weight +127, act1 weight -128
        write_cfg(REG_OUTPUT, 64'h0000_0000_0080_7F01);
        write_cfg(REG_BATCH, 64'd3);

        // table still cleared from reset: only the output bias decides
        for (i = 0; i < FEATURES; i++)
        begin
            send_feature(8'hFF);
        end
        // table extremes at both ends of the address range
        send_table(8'hFF, 8'hFF);
        send_table(8'h00, 8'h00);
        send_table(8'h80, 8'hC8);
        // table load in the middle of a sample, partial sums must survive it;
        // both lookups end at 255 so the output total lands exactly on zero
        for (i = 0; i < FEATURES; i++)
        begin
            if (i == 3)
            begin
                send_table(8'h00, 8'hFF);
            end
            send_feature(8'h00);
        end
        // alternating zero and full-scale features, third sample ends the batch
        for (i = 0; i < FEATURES; i++)
        begin
            send_feature(i[0] ? 8'hFF : 8'h00);
        end

        // ---------------- random phases ----------------
        for (phase = 0; phase < 10; phase++)
        begin
            settle_block();
            style = (phase < 4) ? coeff_style_t'(phase)
                                : ((phase % 2 == 0) ? STYLE_SMALL : STYLE_RANDOM);
            write_cfg(REG_HIDDEN0, pick_coeffs(style));
            write_cfg(REG_HIDDEN1, pick_coeffs(coeff_style_t'((int'(style) + phase) % 4)));
            wo = pick_coeffs(style);
            write_cfg(REG_OUTPUT, {40'd0, wo[23:0]});
            // keep the batch size above the running count so markers keep coming;
            // the last phase takes the largest size
            if (phase == 0)
            begin
                bsz = sb.sample_idx + 16'd1;
            end
            else if (phase == 9)
            begin
                bsz = 16'hFFFF;
            end
            else
            begin
                bsz = sb.sample_idx + 16'($urandom_range(6, 1));
            end
            write_cfg(REG_BATCH, {48'd0, bsz});

            case (phase % 3)
                0:
                begin
                    send_max_gap = 19;
                    recv_max_gap = 19;
                end
                1:
                begin
                    send_max_gap = 0;
                    recv_max_gap = 19;
                end
                default:
                begin
                    send_max_gap = 19;
                    recv_max_gap = 0;
                end
            endcase
            // a stretch with no idling at all
            if (phase == 4)
            begin
                send_max_gap = 0;
                recv_max_gap = 0;
            end
            // sender at full rate while the sink holds off: input must stall
            if (phase == 5)
            begin
                send_max_gap = 0;
                recv_max_gap = 19;
                hold_pending = 1'b1;
            end
            // one full table load so lookups see varied contents
            if (phase == 1)
            begin
                for (i = 0; i < 256; i++)
                begin
                    send_table(i[7:0], 8'($urandom));
                end
            end
            n = (phase == 5) ? 100 : 50;
            for (i = 0; i < n; i++)
            begin
                send_random_word();
            end
        end

        // ---------------- batch size corner cases ----------------
        settle_block();
        send_max_gap = 0;
        recv_max_gap = 0;
        write_cfg(REG_BATCH, 64'd1000);
        run_samples(4);
        settle_block();
        // batch size lowered below the running count: the count keeps climbing
        // and no marker comes on these samples
        write_cfg(REG_BATCH, 64'd2);
        run_samples(4);
        settle_block();
        // batch size zero: the marker would only fall on count 65535
        write_cfg(REG_BATCH, 64'd0);
        run_samples(4);
        settle_block();

        // anything still predicted at this point never arrived
        sb.errors += sb.pending_q.size();

        $display("covered %0d input words (%0d table loads) and %0d result words, %0d batch ends",
                 sb.words_noted, sb.table_loads, sb.verdicts_checked, sb.batch_ends);
        $display("clamp ends, mid-sample table loads, a long stall, small and zero batch sizes");
        if (sb.errors == 0)
        begin
            $display("tb_mlp_lut_sigmoid_classifier: clean");
        end
        else
        begin
            $display("tb_mlp_lut_sigmoid_classifier: errors");
        end
        $finish;
    end

endmodule
